FILE: hdl/sltd_pkg.sv
`default_nettype none

package sltd_pkg;

    localparam logic [7:0] START_BYTE = 8'h61;

    // Depth of the command queue between the parser and the emitter.
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    // Register indexes on the configuration port.
    localparam logic REG_CONTROL_TYPE = 1'b0;
    localparam logic REG_CHANNEL_TYPE = 1'b1;

    // Header step of the emitter.
    typedef enum logic [1:0] {
        HS_START,
        HS_LEN_HI,
        HS_LEN_LO,
        HS_TYPE
    } t_hdr_step;

    // One command from the parser: either a whole accepted header, which
    // expands into four words, or a single payload word.
    typedef struct packed {
        logic       is_hdr;
        logic [7:0] len_hi;
        logic [7:0] len_lo;
        logic [7:0] data;
        logic       last;
        logic       chan;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic empty;
        logic full;
        t_cmd head;
    } t_q_stat;

endpackage

`default_nettype wire

FILE: hdl/sltd_front.sv
`default_nettype none

module sltd_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_accept,
    input  wire  [7:0]          i_byte,
    input  wire  [7:0]          i_ctrl_code,
    input  wire  [7:0]          i_chan_code,
    output sltd_pkg::t_push     o_push
);
    import sltd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_TYPE,
        PH_PAYLOAD
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [7:0]  r_len_lo, n_len_lo;
    logic [15:0] r_remaining, n_remaining;
    logic        r_chan, n_chan;

    logic        is_chan, is_ctrl, zero_len;
    logic [15:0] rem_dec;

    assign is_chan  = (i_byte == i_chan_code);
    assign is_ctrl  = (i_byte == i_ctrl_code);
    assign zero_len = ({r_len_hi, r_len_lo} == 16'd0);
    assign rem_dec  = r_remaining - 16'd1;

    always_comb begin
        n_phase     = r_phase;
        n_len_hi    = r_len_hi;
        n_len_lo    = r_len_lo;
        n_remaining = r_remaining;
        n_chan      = r_chan;
        o_push.push = 1'b0;
        o_push.cmd  = '{is_hdr: 1'b1, len_hi: r_len_hi, len_lo: r_len_lo,
                        data: i_byte, last: zero_len, chan: is_chan};
        if (i_accept) begin
            unique case (r_phase)
                PH_LEN_HI: begin
                    n_len_hi = i_byte;
                    n_phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len_lo = i_byte;
                    n_phase  = PH_TYPE;
                end
                PH_TYPE: begin
                    if (is_chan || is_ctrl) begin
                        o_push.push = 1'b1;
                        n_chan      = is_chan;
                        n_remaining = {r_len_hi, r_len_lo};
                        n_phase     = zero_len ? PH_HUNT : PH_PAYLOAD;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_PAYLOAD: begin
                    o_push.push       = 1'b1;
                    o_push.cmd.is_hdr = 1'b0;
                    o_push.cmd.last   = (rem_dec == 16'd0);
                    o_push.cmd.chan   = r_chan;
                    n_remaining       = rem_dec;
                    if (rem_dec == 16'd0) begin
                        n_phase = PH_HUNT;
                    end
                end
                default: begin
                    n_phase = (i_byte == START_BYTE) ? PH_LEN_HI : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_len_hi    <= 8'd0;
            r_len_lo    <= 8'd0;
            r_remaining <= 16'd0;
            r_chan      <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_len_hi    <= n_len_hi;
            r_len_lo    <= n_len_lo;
            r_remaining <= n_remaining;
            r_chan      <= n_chan;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sltd_queue.sv
`default_nettype none

module sltd_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  sltd_pkg::t_push     i_push,
    input  wire                 i_pop,
    output sltd_pkg::t_q_stat   o_stat
);
    import sltd_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, n_wp;
    logic [Q_AW-1:0] r_rp, n_rp;
    logic [Q_CW-1:0] r_count, n_count;
    logic            do_push, do_pop;

    assign o_stat.empty = (r_count == Q_CW'(0));
    assign o_stat.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_stat.head  = r_mem[r_rp];

    assign do_push = i_push.push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_comb begin
        n_wp    = do_push ? Q_AW'((r_wp + 1'b1) % Q_DEPTH) : r_wp;
        n_rp    = do_pop  ? Q_AW'((r_rp + 1'b1) % Q_DEPTH) : r_rp;
        n_count = r_count + Q_CW'(do_push) - Q_CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sltd_back.sv
`default_nettype none

module sltd_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  sltd_pkg::t_q_stat   i_q,
    output logic                o_q_pop,
    input  wire                 i_pop,
    output logic                o_empty,
    output logic [7:0]          o_byte,
    output logic                o_first,
    output logic                o_last,
    output logic                o_chan
);
    import sltd_pkg::*;

    t_hdr_step  r_step, n_step;
    logic       r_valid, n_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_first, n_first;
    logic       r_last, n_last;
    logic       r_chan, n_chan;
    logic       advance, take;

    // The output register takes queued words when empty or being drained.
    assign advance = !r_valid || i_pop;
    assign take    = advance && !i_q.empty;

    always_comb begin
        n_step  = r_step;
        n_valid = r_valid && !i_pop;
        n_byte  = r_byte;
        n_first = r_first;
        n_last  = r_last;
        n_chan  = r_chan;
        o_q_pop = 1'b0;
        if (take) begin
            n_valid = 1'b1;
            n_chan  = i_q.head.chan;
            n_first = 1'b0;
            n_last  = 1'b0;
            if (i_q.head.is_hdr) begin
                unique case (r_step)
                    HS_START: begin
                        n_byte  = START_BYTE;
                        n_first = 1'b1;
                        n_step  = HS_LEN_HI;
                    end
                    HS_LEN_HI: begin
                        n_byte = i_q.head.len_hi;
                        n_step = HS_LEN_LO;
                    end
                    HS_LEN_LO: begin
                        n_byte = i_q.head.len_lo;
                        n_step = HS_TYPE;
                    end
                    HS_TYPE: begin
                        n_byte  = i_q.head.data;
                        n_last  = i_q.head.last;
                        n_step  = HS_START;
                        o_q_pop = 1'b1;
                    end
                    default: begin
                        n_step = HS_START;
                    end
                endcase
            end else begin
                n_byte  = i_q.head.data;
                n_last  = i_q.head.last;
                o_q_pop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= HS_START;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_first <= n_first;
        r_last  <= n_last;
        r_chan  <= n_chan;
    end

    assign o_empty = !r_valid;
    assign o_byte  = r_byte;
    assign o_first = r_first;
    assign o_last  = r_last;
    assign o_chan  = r_chan;

endmodule

`default_nettype wire

FILE: hdl/sync_length_type_deframer.sv
// Channel   Handshake                         Words
// rx        push / full                       i_rx_byte
// frame     empty / pop                       o_out_byte, o_first_of_frame,
//                                             o_last_of_frame, o_is_channel_frame
// config    psel, penable, pwrite, pready     paddr, pwdata, prdata
//
// A received byte is taken while full is low, and the parser handles one byte per cycle.
// An accepted header becomes one queue entry that the emitter expands into four
// words, one per cycle while the output register is free or popped, as the parser
// runs on; the eight-entry command queue absorbs that backlog, so bytes are
// accepted back to back while words are popped. The first word caused by a byte
// passes through the queue and then the output register. full rises only when
// the frame side holds off long enough to fill the queue. Reset is synchronous;
// it clears the parser, queue and output register.
`default_nettype none

module sync_length_type_deframer (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       push,
    output logic                      full,
    input  wire  [7:0]                i_rx_byte,
    output logic                      empty,
    input  wire                       pop,
    output logic [7:0]                o_out_byte,
    output logic                      o_first_of_frame,
    output logic                      o_last_of_frame,
    output logic                      o_is_channel_frame,
    input  wire                       psel,
    input  wire                       penable,
    input  wire                       pwrite,
    input  wire  [sltd_pkg::CFG_AW-1:0] paddr,
    input  wire  [sltd_pkg::CFG_DW-1:0] pwdata,
    output logic [sltd_pkg::CFG_DW-1:0] prdata,
    output logic                      pready
);
    import sltd_pkg::*;

    logic [7:0] r_ctrl_code;
    logic [7:0] r_chan_code;
    logic       cfg_wr;
    logic       reg_sel;
    t_push      front_push;
    t_q_stat    q_stat;
    logic       q_pop;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_code <= 8'd0;
            r_chan_code <= 8'd1;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_CONTROL_TYPE: r_ctrl_code <= pwdata[7:0];
                REG_CHANNEL_TYPE: r_chan_code <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_CONTROL_TYPE: prdata = {{(CFG_DW-8){1'b0}}, r_ctrl_code};
            REG_CHANNEL_TYPE: prdata = {{(CFG_DW-8){1'b0}}, r_chan_code};
            default:          prdata = '0;
        endcase
    end

    assign full = q_stat.full;

    sltd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (push && !full),
        .i_byte      (i_rx_byte),
        .i_ctrl_code (r_ctrl_code),
        .i_chan_code (r_chan_code),
        .o_push      (front_push)
    );

    sltd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_pop   (q_pop),
        .o_stat  (q_stat)
    );

    sltd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (q_stat),
        .o_q_pop (q_pop),
        .i_pop   (pop),
        .o_empty (empty),
        .o_byte  (o_out_byte),
        .o_first (o_first_of_frame),
        .o_last  (o_last_of_frame),
        .o_chan  (o_is_channel_frame)
    );

    // A frame always opens with the start byte.
    a_first_is_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_first_of_frame) |-> (o_out_byte == START_BYTE))
        else $error("first word of a frame is not the start byte");

    // The start word is never also the final word: a header has four words.
    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_first_of_frame) |-> !o_last_of_frame)
        else $error("start word marked as last of frame");

    // Once the start word is taken, the length byte follows straight away.
    a_header_streams: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_first_of_frame) |=> (!empty && !o_first_of_frame))
        else $error("header words did not follow the start word");

endmodule

`default_nettype wire
